// File: rtl/core/rf433_pkg.sv
// Shared types, constants and helper functions for the 433 MHz remote pulse decoder.
package rf433_pkg;

   // Field widths
   localparam int PulseWidth  = 16;
   localparam int UnitWidth   = 11;
   localparam int CodeWidth   = 24;
   localparam int CountWidth  = 6;
   localparam int CsrIdxWidth = 2;
   localparam int CsrWidth    = 16;

   // Frame shape
   localparam logic [CountWidth-1:0] FrameTimings = 6'd49;
   localparam logic [CountWidth-1:0] CountLimit   = 6'd50;
   localparam int                    SyncDivisor  = 31;

   // Register indexes of the configuration port
   localparam logic [CsrIdxWidth-1:0] CSR_SYNC_UNIT_MIN  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SYNC_UNIT_MAX  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_LONG_THRESHOLD = 2'd2;

   // Reset values of the registers
   localparam logic [UnitWidth-1:0]  SyncUnitMinReset   = 11'd290;
   localparam logic [UnitWidth-1:0]  SyncUnitMaxReset   = 11'd400;
   localparam logic [PulseWidth-1:0] LongThresholdReset = 16'd700;

   // Code patterns
   localparam logic [19:0] MotionPrefix = 20'b00000100000000000001;
   localparam logic [3:0]  NibbleOn     = 4'b0001;
   localparam logic [3:0]  NibbleOff    = 4'b0100;
   localparam int          NumButtons   = 5;
   localparam logic [9:0]  ButtonPattern [NumButtons] = '{
      10'b0001010101, 10'b0100010101, 10'b0101000101, 10'b0101010001, 10'b0101010100
   };

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_LENGTH = 3'd1,
      ST_BAD_SYNC   = 3'd2,
      ST_BAD_PAIR   = 3'd3,
      ST_BAD_CHAN   = 3'd4,
      ST_BAD_BUTTON = 3'd5,
      ST_BAD_POWER  = 3'd6
   } status_type;

   // Frame state handed to the result check
   typedef struct packed {
      logic [CountWidth-1:0] count;
      status_type            first_error;
      logic [CodeWidth-1:0]  code;
   } frame_type;

   // Decoded result
   typedef struct packed {
      status_type           status;
      logic [CodeWidth-1:0] raw_code;
      logic [4:0]           channel_bits;
      logic [2:0]           button_index;
      logic                 power_on;
      logic                 motion_frame;
      logic                 motion_on;
   } result_type;

   // Sync bound in microseconds: unit * 31, fits 17 bits
   function automatic logic [PulseWidth:0] unit_to_time(input logic [UnitWidth:0] unit);
      logic [PulseWidth+1:0] t;
      t = ({6'd0, unit} << 5) - {6'd0, unit};
      return t[PulseWidth:0];
   endfunction

endpackage

// File: rtl/core/rf433_req_if.sv
// Pulse timing channel: valid/ready with pulse duration and frame end flag.
interface rf433_req_if;
   import rf433_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [PulseWidth-1:0] pulse_time;
   logic                  frame_end;

   modport source (output valid, output pulse_time, output frame_end, input ready);
   modport sink   (input valid, input pulse_time, input frame_end, output ready);
endinterface

// File: rtl/core/rf433_rsp_if.sv
// Decoded frame channel: valid/ready with status and decoded code fields.
interface rf433_rsp_if;
   import rf433_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [2:0]           status;
   logic [CodeWidth-1:0] raw_code;
   logic [4:0]           channel_bits;
   logic [2:0]           button_index;
   logic                 power_on;
   logic                 motion_frame;
   logic                 motion_on;

   modport source (output valid, output status, output raw_code, output channel_bits,
                   output button_index, output power_on, output motion_frame,
                   output motion_on, input ready);
   modport sink   (input valid, input status, input raw_code, input channel_bits,
                   input button_index, input power_on, input motion_frame,
                   input motion_on, output ready);
endinterface

// File: rtl/core/rf433_frame_check.sv
// Combinational check of a completed frame: length, errors, channel, button, power.
module rf433_frame_check
   import rf433_pkg::*;
(
   input  frame_type  frame,
   output result_type result
);

   logic [CodeWidth-1:0] code;
   logic [4:0]           chan;
   logic                 chan_bad;
   logic [9:0]           pattern;
   logic                 button_hit;
   logic [2:0]           button;
   logic [3:0]           nibble;
   logic                 motion;

   assign code    = frame.code;
   assign pattern = code[13:4];
   assign nibble  = code[3:0];
   assign motion  = (code[23:4] == MotionPrefix);

   // Channel pairs: 00 sets the bit, 01 is clear, anything else is an error
   always_comb begin
      chan     = '0;
      chan_bad = 1'b0;
      for (int k = 0; k < 5; k++) begin
         chan[k]  = (code[23-2*k -: 2] == 2'b00);
         chan_bad = chan_bad | code[23-2*k];
      end
   end

   // Button pattern lookup
   always_comb begin
      button_hit = 1'b0;
      button     = '0;
      for (int k = 0; k < NumButtons; k++) begin
         if (!button_hit && pattern == ButtonPattern[k]) begin
            button_hit = 1'b1;
            button     = 3'(k);
         end
      end
   end

   // Result with precedence: length, first timing error, channel, button, power
   always_comb begin
      result              = '0;
      result.status       = ST_OK;
      if (frame.count != FrameTimings) begin
         result.status = ST_BAD_LENGTH;
      end else if (frame.first_error != ST_OK) begin
         result.status = frame.first_error;
      end else begin
         result.raw_code     = code;
         result.motion_frame = motion;
         result.motion_on    = motion && (nibble != NibbleOff);
         if (chan_bad) begin
            result.status = ST_BAD_CHAN;
         end else if (!button_hit) begin
            result.status = ST_BAD_BUTTON;
         end else if (nibble != NibbleOn && nibble != NibbleOff) begin
            result.status = ST_BAD_POWER;
         end else begin
            result.channel_bits = chan;
            result.button_index = button;
            result.power_on     = (nibble == NibbleOn);
         end
      end
   end

endmodule

// File: rtl/core/rf433_remote_pulse_decoder_top.sv
// Top level of the 433 MHz remote pulse decoder: input stage, frame state, result register.
//
// Usage:
//   req_bus carries one pulse duration per beat, with frame_end on the last
//   timing of a frame. Every frame gives exactly one beat on rsp_bus at its
//   last timing; other timings give none. A good frame has 49 timings: the
//   sync pulse and 24 short/long pairs.
//   csr_wr_en/csr_index/csr_wdata write sync_unit_min (0), sync_unit_max (1)
//   and long_threshold (2); write only while no frame is in progress.
// Timing:
//   One beat is accepted per cycle while the input stage can advance. A beat
//   is registered at acceptance and decoded in the following cycle; the result
//   is loaded into the result register when the last timing leaves the input
//   stage, and from that register it shows on rsp_bus. The rate is set by the
//   single result register: one frame result may wait there while new timings
//   keep arriving; only a second frame end stalls until it is taken.
// Reset:
//   reset (synchronous, active high) empties both stages, clears the frame
//   state and loads the register defaults 290, 400 and 700.
module rf433_remote_pulse_decoder_top
   import rf433_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   rf433_req_if.sink              req_bus,
   rf433_rsp_if.source            rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrWidth-1:0]    csr_wdata
);

   // Configuration registers
   logic [UnitWidth-1:0]  sync_min_ff;
   logic [UnitWidth-1:0]  sync_max_ff;
   logic [PulseWidth-1:0] long_thr_ff;

   // Input stage
   logic                  in_valid_ff;
   logic [PulseWidth-1:0] in_pulse_ff;
   logic                  in_last_ff;

   // Frame state
   logic [CountWidth-1:0] count_ff,      count_in;
   logic                  first_long_ff, first_long_in;
   logic [CodeWidth-1:0]  code_ff,       code_in;
   status_type            error_ff,      error_in;

   // Result register
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic          advance;
   logic          sync_ok;
   logic          second_long;
   logic [PulseWidth:0] sync_lo;
   logic [PulseWidth:0] sync_hi;
   frame_type     frame;
   result_type    result;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_min_ff <= SyncUnitMinReset;
         sync_max_ff <= SyncUnitMaxReset;
         long_thr_ff <= LongThresholdReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SYNC_UNIT_MIN:  sync_min_ff <= csr_wdata[UnitWidth-1:0];
            CSR_SYNC_UNIT_MAX:  sync_max_ff <= csr_wdata[UnitWidth-1:0];
            CSR_LONG_THRESHOLD: long_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage advances unless a frame end meets a result still waiting
   assign advance       = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // Input stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_pulse_ff <= req_bus.pulse_time;
         in_last_ff  <= req_bus.frame_end;
      end
   end

   // Sync check without division: unit > min and unit < max on pulse/31
   assign sync_lo     = unit_to_time({1'b0, sync_min_ff} + 12'd1);
   assign sync_hi     = unit_to_time({1'b0, sync_max_ff});
   assign sync_ok     = ({1'b0, in_pulse_ff} >= sync_lo) && ({1'b0, in_pulse_ff} < sync_hi);
   assign second_long = (in_pulse_ff >= long_thr_ff);

   // Next frame state for the beat in the input stage
   always_comb begin
      first_long_in = first_long_ff;
      code_in       = code_ff;
      error_in      = error_ff;
      if (count_ff == '0) begin
         if (!sync_ok && error_ff == ST_OK) begin
            error_in = ST_BAD_SYNC;
         end
      end else if (count_ff < FrameTimings) begin
         if (count_ff[0]) begin
            first_long_in = (in_pulse_ff > long_thr_ff);
         end else if (first_long_ff != second_long) begin
            code_in = {code_ff[CodeWidth-2:0], first_long_ff};
         end else if (error_ff == ST_OK) begin
            error_in = ST_BAD_PAIR;
         end
      end
      count_in = (count_ff < CountLimit) ? count_ff + 6'd1 : count_ff;
   end

   assign frame = '{count: count_in, first_error: error_in, code: code_in};

   rf433_frame_check u_check (
      .frame  (frame),
      .result (result)
   );

   // Frame state: updated per beat, cleared at frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         first_long_ff <= 1'b0;
         code_ff       <= '0;
         error_ff      <= ST_OK;
      end else if (advance) begin
         if (in_last_ff) begin
            count_ff      <= '0;
            first_long_ff <= 1'b0;
            code_ff       <= '0;
            error_ff      <= ST_OK;
         end else begin
            count_ff      <= count_in;
            first_long_ff <= first_long_in;
            code_ff       <= code_in;
            error_ff      <= error_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_ff.status;
   assign rsp_bus.raw_code     = rsp_ff.raw_code;
   assign rsp_bus.channel_bits = rsp_ff.channel_bits;
   assign rsp_bus.button_index = rsp_ff.button_index;
   assign rsp_bus.power_on     = rsp_ff.power_on;
   assign rsp_bus.motion_frame = rsp_ff.motion_frame;
   assign rsp_bus.motion_on    = rsp_ff.motion_on;

endmodule

// File: dv/rf433_frame_checker.sv
// Frame checker for the 433 MHz remote decoder: tracks pulse beats and checks each result beat.
`timescale 1ns / 100ps

module rf433_frame_checker
   import rf433_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   rf433_req_if                   req_mon,
   rf433_rsp_if                   rsp_mon,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrWidth-1:0]    csr_wdata,
   output int                     fail_count,
   output int                     outstanding
);

   // Register copies
   logic [UnitWidth-1:0]  unit_lo;
   logic [UnitWidth-1:0]  unit_hi;
   logic [PulseWidth-1:0] long_limit;

   // Frame in progress
   logic [CountWidth-1:0] timings_seen;
   logic                  lead_long;
   logic [CodeWidth-1:0]  bits_so_far;
   status_type            early_err;

   result_type pending_results[$];
   int         sync_units;
   logic       trail_long;
   result_type want;

   // Full decode of a finished frame, precedence: length, sync/pair, channel, button, power
   function automatic result_type decode_frame(input logic [CountWidth-1:0] seen,
                                               input status_type err,
                                               input logic [CodeWidth-1:0] code);
      result_type r;
      logic [1:0] pair;
      logic       hit;
      r = '0;
      r.status = ST_OK;
      if (seen != FrameTimings) begin
         r.status = ST_BAD_LENGTH;
         return r;
      end
      if (err != ST_OK) begin
         r.status = err;
         return r;
      end
      r.raw_code     = code;
      r.motion_frame = (code[23:4] == MotionPrefix);
      r.motion_on    = r.motion_frame && (code[3:0] != NibbleOff);
      for (int k = 0; k < 5; k++) begin
         pair = code[23-2*k -: 2];
         if (r.status == ST_OK) begin
            if (pair == 2'b00) r.channel_bits[k] = 1'b1;
            else if (pair != 2'b01) r.status = ST_BAD_CHAN;
         end
      end
      if (r.status == ST_OK) begin
         hit = 1'b0;
         for (int k = 0; k < NumButtons; k++) begin
            if (!hit && ButtonPattern[k] == code[13:4]) begin
               hit = 1'b1;
               r.button_index = k[2:0];
            end
         end
         if (!hit) r.status = ST_BAD_BUTTON;
      end
      if (r.status == ST_OK) begin
         if (code[3:0] == NibbleOn) r.power_on = 1'b1;
         else if (code[3:0] == NibbleOff) r.power_on = 1'b0;
         else r.status = ST_BAD_POWER;
      end
      if (r.status != ST_OK) begin
         r.channel_bits = '0;
         r.button_index = '0;
         r.power_on     = 1'b0;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input int exp_val, input int got_val);
      if (exp_val != got_val) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         unit_lo      = SyncUnitMinReset;
         unit_hi      = SyncUnitMaxReset;
         long_limit   = LongThresholdReset;
         timings_seen = '0;
         lead_long    = 1'b0;
         bits_so_far  = '0;
         early_err    = ST_OK;
         pending_results.delete();
         fail_count   = 0;
         outstanding <= 0;
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SYNC_UNIT_MIN:  unit_lo = csr_wdata[UnitWidth-1:0];
               CSR_SYNC_UNIT_MAX:  unit_hi = csr_wdata[UnitWidth-1:0];
               CSR_LONG_THRESHOLD: long_limit = csr_wdata;
               default: ;
            endcase
         end

         // result beat against the oldest frame
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               $error("result beat with no frame outstanding");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", want.status, rsp_mon.status);
               check_field("raw_code", want.raw_code, rsp_mon.raw_code);
               check_field("channel_bits", want.channel_bits, rsp_mon.channel_bits);
               check_field("button_index", want.button_index, rsp_mon.button_index);
               check_field("power_on", want.power_on, rsp_mon.power_on);
               check_field("motion_frame", want.motion_frame, rsp_mon.motion_frame);
               check_field("motion_on", want.motion_on, rsp_mon.motion_on);
            end
         end

         // pulse beat
         if (req_mon.valid && req_mon.ready) begin
            if (timings_seen == '0) begin
               sync_units = int'(req_mon.pulse_time) / SyncDivisor;
               if (!(sync_units > int'(unit_lo) && sync_units < int'(unit_hi))
                   && early_err == ST_OK)
                  early_err = ST_BAD_SYNC;
            end else if (timings_seen < FrameTimings) begin
               if (timings_seen[0]) begin
                  lead_long = req_mon.pulse_time > long_limit;
               end else begin
                  trail_long = req_mon.pulse_time >= long_limit;
                  if (!lead_long && trail_long)
                     bits_so_far = {bits_so_far[CodeWidth-2:0], 1'b0};
                  else if (lead_long && !trail_long)
                     bits_so_far = {bits_so_far[CodeWidth-2:0], 1'b1};
                  else if (early_err == ST_OK)
                     early_err = ST_BAD_PAIR;
               end
            end
            // count saturates, later timings are dropped
            if (timings_seen < CountLimit) timings_seen = timings_seen + 1'b1;

            if (req_mon.frame_end) begin
               pending_results.push_back(decode_frame(timings_seen, early_err, bits_so_far));
               timings_seen = '0;
               lead_long    = 1'b0;
               bits_so_far  = '0;
               early_err    = ST_OK;
            end
         end
         outstanding <= pending_results.size();
      end
   end

endmodule

// File: dv/tb.sv
// Testbench top for the 433 MHz remote decoder: clock, reset, pulse stimulus and verdict.
`timescale 1ns / 100ps

module tb
   import rf433_pkg::*;
();

   localparam int StallLimit = 5000;

   typedef enum {FR_GOOD, FR_BAD_SYNC, FR_BAD_PAIR, FR_SHORT, FR_LONG, FR_NOISE} frame_kind_type;
   typedef enum {CD_VALID, CD_MOTION, CD_BAD_CHAN, CD_BAD_BUTTON, CD_BAD_POWER,
                 CD_RANDOM} code_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   csr_wr_en;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CsrWidth-1:0]    csr_wdata;

   int fail_count;
   int outstanding;
   int beats_sent   = 0;
   int frames_sent  = 0;
   int stall_cycles = 0;
   bit hold_done    = 1'b0;

   // Settings as last written, used to aim the pulses
   int unit_lo_cfg = SyncUnitMinReset;
   int unit_hi_cfg = SyncUnitMaxReset;
   int long_cfg    = LongThresholdReset;

   wire quiet_stretch = (beats_sent >= 300) && (beats_sent < 500);

   always #10 clock = ~clock;

   rf433_req_if req_bus ();
   rf433_rsp_if rsp_bus ();

   rf433_remote_pulse_decoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rf433_frame_checker u_frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Watchdog: cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: random stalls, one long hold-off so the decoder backs up
   initial begin
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && beats_sent >= 700) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (600) @(posedge clock);
         end else begin
            rsp_bus.ready <= quiet_stretch || ($urandom_range(0, 99) >= 16);
            @(posedge clock);
         end
      end
   end

   // Pulse value helpers
   function automatic logic [15:0] pulse_at_least(input int lo);
      int sel;
      sel = $urandom_range(0, 3);
      if (lo > 65535) return 16'hFFFF;
      if (sel == 0) return lo[15:0];
      if (sel == 1) return 16'($urandom_range(lo, (lo + 2000 > 65535) ? 65535 : lo + 2000));
      return 16'($urandom_range(lo, 65535));
   endfunction

   function automatic logic [15:0] pulse_at_most(input int hi);
      int sel;
      sel = $urandom_range(0, 3);
      if (hi < 0) return 16'h0000;
      if (sel == 0) return hi[15:0];
      if (sel == 1) return 16'($urandom_range((hi > 2000) ? hi - 2000 : 0, hi));
      return 16'($urandom_range(0, hi));
   endfunction

   // first pulse of a pair: long is strictly above the threshold
   function automatic logic [15:0] lead_pulse(input logic is_long);
      return is_long ? pulse_at_least(long_cfg + 1) : pulse_at_most(long_cfg);
   endfunction

   // second pulse of a pair: long is at or above the threshold
   function automatic logic [15:0] trail_pulse(input logic is_long);
      return is_long ? pulse_at_least(long_cfg) : pulse_at_most(long_cfg - 1);
   endfunction

   function automatic logic [15:0] sync_pulse(input logic in_window);
      int unit;
      int sel;
      int t;
      sel = $urandom_range(0, 3);
      if (in_window && unit_hi_cfg > unit_lo_cfg + 1) begin
         if (sel == 0) unit = unit_lo_cfg + 1;
         else if (sel == 1) unit = unit_hi_cfg - 1;
         else unit = $urandom_range(unit_lo_cfg + 1, unit_hi_cfg - 1);
      end else if (in_window) begin
         unit = $urandom_range(0, 2047);
      end else begin
         if (sel == 0) unit = unit_lo_cfg;
         else if (sel == 1) unit = unit_hi_cfg;
         else if (sel == 2) unit = $urandom_range(0, unit_lo_cfg);
         else unit = $urandom_range(unit_hi_cfg, 2114);
      end
      t = unit * SyncDivisor + $urandom_range(0, 30);
      return (t > 65535) ? 16'hFFFF : t[15:0];
   endfunction

   function automatic logic [CodeWidth-1:0] build_code(input code_kind_type scn);
      logic [CodeWidth-1:0] code;
      logic [3:0]           nib;
      int                   k;
      for (k = 0; k < 5; k++)
         code[23-2*k -: 2] = $urandom_range(0, 1) ? 2'b00 : 2'b01;
      code[13:4] = ButtonPattern[3'($urandom_range(0, NumButtons - 1))];
      code[3:0]  = $urandom_range(0, 1) ? NibbleOn : NibbleOff;
      case (scn)
         CD_MOTION: begin
            code[23:4] = MotionPrefix;
            if ($urandom_range(0, 1)) code[3:0] = 4'($urandom_range(0, 15));
         end
         CD_BAD_CHAN: begin
            k = $urandom_range(0, 4);
            code[23-2*k -: 2] = 2'($urandom_range(2, 3));
         end
         CD_BAD_BUTTON: code[13:4] = 10'($urandom_range(0, 1023));
         CD_BAD_POWER: begin
            nib = 4'($urandom_range(0, 15));
            while (nib == NibbleOn || nib == NibbleOff) nib = 4'($urandom_range(0, 15));
            code[3:0] = nib;
         end
         CD_RANDOM: code = 24'($urandom_range(0, 24'hFFFFFF));
         default: ;
      endcase
      return code;
   endfunction

   // One pulse beat, with random idle cycles ahead of it
   task automatic send_beat(input logic [15:0] pulse, input logic last);
      while (!quiet_stretch && $urandom_range(0, 99) < 16) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.pulse_time <= pulse;
      req_bus.frame_end  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_frame(input frame_kind_type kind, input code_kind_type scn);
      logic [15:0]          seq [0:60];
      logic [CodeWidth-1:0] code;
      logic                 cls;
      int                   len;
      int                   bad_pair;
      int                   k;
      code   = build_code(scn);
      seq[0] = sync_pulse(kind != FR_BAD_SYNC);
      bad_pair = -1;
      if (kind == FR_BAD_PAIR || (kind == FR_BAD_SYNC && $urandom_range(0, 1)))
         bad_pair = $urandom_range(0, 23);
      // bit 1 is long-short, bit 0 short-long; a broken pair is two of a kind
      for (k = 0; k < 24; k++) begin
         if (k == bad_pair) begin
            cls = 1'($urandom_range(0, 1));
            seq[1+2*k] = lead_pulse(cls);
            seq[2+2*k] = trail_pulse(cls);
         end else begin
            seq[1+2*k] = lead_pulse(code[23-k]);
            seq[2+2*k] = trail_pulse(!code[23-k]);
         end
      end
      for (k = 49; k < 61; k++) seq[k] = 16'($urandom_range(0, 65535));
      case (kind)
         FR_SHORT: len = $urandom_range(1, 48);
         FR_LONG:  len = $urandom_range(50, 61);
         FR_NOISE: begin
            len = $urandom_range(1, 61);
            for (k = 0; k < 49; k++) seq[k] = 16'($urandom_range(0, 65535));
         end
         default:  len = 49;
      endcase
      for (k = 0; k < len; k++) send_beat(seq[k], k == len - 1);
      frames_sent++;
   endtask

   // Wait for every result, then let the pipeline settle
   task automatic drain(input int settle);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic program_regs(input int lo, input int hi, input int thr);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SYNC_UNIT_MIN;
      csr_wdata <= lo[15:0];
      @(posedge clock);
      csr_index <= CSR_SYNC_UNIT_MAX;
      csr_wdata <= hi[15:0];
      @(posedge clock);
      csr_index <= CSR_LONG_THRESHOLD;
      csr_wdata <= thr[15:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      unit_lo_cfg = lo;
      unit_hi_cfg = hi;
      long_cfg    = thr;
   endtask

   task automatic program_random();
      int lo;
      int hi;
      lo = $urandom_range(1, 1500);
      hi = lo + $urandom_range(2, 400);
      program_regs(lo, (hi > 2047) ? 2047 : hi, $urandom_range(50, 5000));
   endtask

   // Random frames up to a beat count; the opening frames walk through every case
   task automatic run_frames(input int beat_goal, input int frame_goal);
      frame_kind_type kind;
      code_kind_type  scn;
      int             sel;
      while (beats_sent < beat_goal || frames_sent < frame_goal) begin
         scn  = CD_VALID;
         kind = FR_GOOD;
         if (frames_sent < 6) begin
            scn = code_kind_type'(frames_sent);
         end else if (frames_sent < 11) begin
            kind = frame_kind_type'(frames_sent - 5);
         end else begin
            sel = $urandom_range(0, 99);
            if (sel < 9) kind = FR_BAD_SYNC;
            else if (sel < 18) kind = FR_BAD_PAIR;
            else if (sel < 26) kind = FR_SHORT;
            else if (sel < 33) kind = FR_LONG;
            else if (sel < 38) kind = FR_NOISE;
            sel = $urandom_range(0, 99);
            if (sel < 8) scn = CD_MOTION;
            else if (sel < 14) scn = CD_BAD_CHAN;
            else if (sel < 20) scn = CD_BAD_BUTTON;
            else if (sel < 26) scn = CD_BAD_POWER;
            else if (sel < 30) scn = CD_RANDOM;
         end
         send_frame(kind, scn);
      end
      drain(4);
   endtask

   // Stimulus
   initial begin
      req_bus.valid      = 1'b0;
      req_bus.pulse_time = '0;
      req_bus.frame_end  = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_SYNC_UNIT_MIN;
      csr_wdata          = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short frames with extreme pulses, all length errors
      send_beat(16'h0000, 1'b1);
      send_beat(16'hFFFF, 1'b1);
      send_beat(16'hAAAA, 1'b0);
      send_beat(16'h5555, 1'b1);
      send_beat(16'd10695, 1'b0);
      send_beat(16'd700, 1'b0);
      send_beat(16'd701, 1'b1);
      drain(4);

      // default settings
      run_frames(260, 0);
      // widest sync window, zero threshold
      program_regs(0, 2047, 0);
      run_frames(480, 0);
      // empty sync window, top threshold
      program_regs(2047, 0, 65535);
      run_frames(620, 0);
      program_random();
      run_frames(860, 0);
      // narrowest sync window
      program_regs(0, 2, 65534);
      run_frames(1060, 0);
      program_random();
      run_frames(1300, 0);
      program_regs(SyncUnitMinReset, SyncUnitMaxReset, $urandom_range(0, 65535));
      run_frames(1550, 48);

      drain(8);
      if (fail_count == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
